// ===== rtl/core/bmcv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmcv_pkg
// Shared widths, codes, face tables and record types of the box mesh cell
// vertex generator.
// ----------------------------------------------------------------------------
package bmcv_pkg;

	localparam int SIZE_W = 16;
	localparam int DIV_W  = 9;
	localparam int CELL_W = 8;
	localparam int K_W    = 9;
	localparam int POS_W  = 16;
	localparam int NORM_W = 2;
	localparam int TEX_W  = 17;
	localparam int FRAC_T = 16;
	localparam int NUM_W  = K_W + FRAC_T;
	localparam int QUO_W  = 17;
	localparam int OP_W   = 4;
	localparam int IDX_W  = 2;

	localparam int MAX_DIV = 256;

	// cell records between front and back
	localparam int QDEPTH = 2;
	localparam int CNT_W  = $clog2(QDEPTH + 1);
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [OP_W-1:0] OP_LAST = 4'd11;

	localparam logic [IDX_W-1:0] REG_SIZE_X    = 2'd0;
	localparam logic [IDX_W-1:0] REG_SIZE_Y    = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIZE_Z    = 2'd2;
	localparam logic [IDX_W-1:0] REG_DIVISIONS = 2'd3;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd256;
	localparam logic [DIV_W-1:0]  DIV_RESET  = 9'd1;

	localparam logic [TEX_W-1:0]  TEX_ONE  = 17'h10000;
	localparam logic [NORM_W-1:0] NORM_POS = 2'b01;
	localparam logic [NORM_W-1:0] NORM_NEG = 2'b11;
	localparam logic [NORM_W-1:0] NORM_NIL = 2'b00;

	localparam logic [2:0] FACE_FRONT  = 3'd0;
	localparam logic [2:0] FACE_BACK   = 3'd1;
	localparam logic [2:0] FACE_RIGHT  = 3'd2;
	localparam logic [2:0] FACE_LEFT   = 3'd3;
	localparam logic [2:0] FACE_TOP    = 3'd4;
	localparam logic [2:0] FACE_BOTTOM = 3'd5;
	localparam logic [2:0] VTX_LAST    = 3'd5;

	// bit v: offset of vertex v along the i or j direction
	localparam logic [5:0] FACE_DI [6] = '{6'b110010, 6'b110100, 6'b110100,
		6'b110010, 6'b110010, 6'b110100};
	localparam logic [5:0] FACE_DJ [6] = '{6'b100110, 6'b010110, 6'b010110,
		6'b100110, 6'b011001, 6'b101001};
	// bit f: face f mirrors that texture axis
	localparam logic [5:0] FACE_U_FLIP = 6'b011001;
	localparam logic [5:0] FACE_V_FLIP = 6'b001111;

	// pq: x at ci, ci+1, z at ci, ci+1, y at cj, cj+1, z at cj, cj+1
	// tq: ci, ci+1, cj, cj+1 over divisions
	typedef struct packed {
		logic [7:0][POS_W-1:0] pq;
		logic [3:0][TEX_W-1:0] tq;
	} cell_rec_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] num;
		logic [OP_W-1:0]  tag;
	} div_req_t;

	typedef struct packed {
		logic             valid;
		logic [QUO_W-1:0] quo;
		logic [OP_W-1:0]  tag;
	} div_rsp_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/bmcv_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmcv_div
// Pipelined restoring divider, one quotient bit per stage, one division
// entering per cycle.
// ----------------------------------------------------------------------------
module bmcv_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [bmcv_pkg::DIV_W-1:0]  divisor,
	input  wire bmcv_pkg::div_req_t          req,
	output bmcv_pkg::div_rsp_t               rsp
);
	import bmcv_pkg::*;

	localparam int NS = QUO_W;

	logic             vld_in  [NS];
	logic [DIV_W-1:0] rem_in  [NS];
	logic [QUO_W-1:0] num_in  [NS];
	logic [QUO_W-1:0] quo_in  [NS];
	logic [OP_W-1:0]  tag_in  [NS];
	logic [DIV_W:0]   trial   [NS];
	logic             fits    [NS];

	logic             vld_s   [NS];
	logic [DIV_W-1:0] rem_s   [NS];
	logic [QUO_W-1:0] num_s   [NS];
	logic [QUO_W-1:0] quo_s   [NS];
	logic [OP_W-1:0]  tag_s   [NS];

	always_comb begin
		// high dividend bits are already below the divisor
		vld_in[0] = req.valid;
		rem_in[0] = DIV_W'(req.num[NUM_W-1:QUO_W]);
		num_in[0] = req.num[QUO_W-1:0];
		quo_in[0] = '0;
		tag_in[0] = req.tag;
		for (int g = 1; g < NS; g++) begin
			vld_in[g] = vld_s[g-1];
			rem_in[g] = rem_s[g-1];
			num_in[g] = num_s[g-1];
			quo_in[g] = quo_s[g-1];
			tag_in[g] = tag_s[g-1];
		end
		for (int g = 0; g < NS; g++) begin
			trial[g] = {rem_in[g], num_in[g][NS-1-g]};
			fits[g]  = (trial[g] >= {1'b0, divisor});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NS; g++) vld_s[g] <= 1'b0;
		end else begin
			for (int g = 0; g < NS; g++) vld_s[g] <= vld_in[g];
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NS; g++) begin
			rem_s[g] <= fits[g] ? DIV_W'(trial[g] - {1'b0, divisor}) : trial[g][DIV_W-1:0];
			num_s[g] <= num_in[g];
			quo_s[g] <= {quo_in[g][QUO_W-2:0], fits[g]};
			tag_s[g] <= tag_in[g];
		end
	end

	assign rsp.valid = vld_s[NS-1];
	assign rsp.quo   = quo_s[NS-1];
	assign rsp.tag   = tag_s[NS-1];

endmodule
`default_nettype wire

// ===== rtl/core/bmcv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmcv_front
// Takes cells, clamps their indices, issues the twelve divisions of a cell
// and gathers the quotients into one cell record.
// ----------------------------------------------------------------------------
module bmcv_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cell_valid,
	output logic                              cell_stall,
	input  wire logic [bmcv_pkg::CELL_W-1:0]  cell_i,
	input  wire logic [bmcv_pkg::CELL_W-1:0]  cell_j,
	input  wire logic [bmcv_pkg::SIZE_W-1:0]  size_x,
	input  wire logic [bmcv_pkg::SIZE_W-1:0]  size_y,
	input  wire logic [bmcv_pkg::SIZE_W-1:0]  size_z,
	input  wire logic [bmcv_pkg::DIV_W-1:0]   eff_div,
	input  wire logic                         rec_pop,
	output logic                              rec_push,
	output bmcv_pkg::cell_rec_t               rec_data
);
	import bmcv_pkg::*;

	// op bit 3: texture; bit 0: index plus one
	// position ops, bits 2:1 select the axis and index
	localparam logic [1:0] OPG_X  = 2'd0;
	localparam logic [1:0] OPG_ZI = 2'd1;
	localparam logic [1:0] OPG_Y  = 2'd2;
	localparam logic [1:0] OPG_ZJ = 2'd3;

	logic              busy_q;
	logic [OP_W-1:0]   op_q;
	logic [CELL_W-1:0] ci_q;
	logic [CELL_W-1:0] cj_q;
	logic [CNT_W-1:0]  reserved_q;

	logic              req_vld_s1;
	logic [NUM_W-1:0]  req_num_s1;
	logic [OP_W-1:0]   req_tag_s1;

	cell_rec_t         rec_q;
	cell_rec_t         rec_d;

	logic              accept;
	logic [CELL_W-1:0] ci_cl;
	logic [CELL_W-1:0] cj_cl;
	logic              use_j;
	logic [K_W-1:0]    k;
	logic [SIZE_W-1:0] size_sel;
	logic [NUM_W-1:0]  num;
	div_req_t          req;
	div_rsp_t          rsp;

	assign cell_stall = (busy_q && (op_q != OP_LAST)) || (reserved_q == CNT_W'(QDEPTH));
	assign accept     = cell_valid && !cell_stall;

	assign ci_cl = ({1'b0, cell_i} >= eff_div) ? CELL_W'(eff_div - 1'b1) : cell_i;
	assign cj_cl = ({1'b0, cell_j} >= eff_div) ? CELL_W'(eff_div - 1'b1) : cell_j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			op_q       <= '0;
			reserved_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				op_q   <= '0;
			end else if (busy_q && (op_q == OP_LAST)) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				op_q <= op_q + 1'b1;
			end
			if (accept && !rec_pop) begin
				reserved_q <= reserved_q + 1'b1;
			end else if (!accept && rec_pop) begin
				reserved_q <= reserved_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ci_q <= ci_cl;
			cj_q <= cj_cl;
		end
	end

	always_comb begin
		use_j = op_q[3] ? op_q[1] : op_q[2];
		k     = {1'b0, (use_j ? cj_q : ci_q)} + K_W'(op_q[0]);
		case (op_q[2:1])
			OPG_X:         size_sel = size_x;
			OPG_ZI, OPG_ZJ: size_sel = size_z;
			OPG_Y:         size_sel = size_y;
			default:       size_sel = size_y;
		endcase
		num = op_q[3] ? {k, FRAC_T'(0)} : NUM_W'(NUM_W'(size_sel) * NUM_W'(k));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else begin
			req_vld_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		req_num_s1 <= num;
		req_tag_s1 <= op_q;
	end

	assign req.valid = req_vld_s1;
	assign req.num   = req_num_s1;
	assign req.tag   = req_tag_s1;

	bmcv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.divisor (eff_div),
		.req     (req),
		.rsp     (rsp)
	);

	always_comb begin
		rec_d = rec_q;
		if (rsp.valid) begin
			if (rsp.tag[3]) begin
				rec_d.tq[rsp.tag[1:0]] = rsp.quo;
			end else begin
				rec_d.pq[rsp.tag[2:0]] = rsp.quo[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_d;
	end

	assign rec_push = rsp.valid && (rsp.tag == OP_LAST);
	assign rec_data = rec_d;

endmodule
`default_nettype wire

// ===== rtl/core/bmcv_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmcv_fifo
// Short queue of finished cell records between front and back.
// ----------------------------------------------------------------------------
module bmcv_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bmcv_pkg::cell_rec_t push_data,
	input  wire logic              pop,
	output bmcv_pkg::cell_rec_t    head,
	output bmcv_pkg::fifo_stat_t   stat
);
	import bmcv_pkg::*;

	cell_rec_t        entries_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_data;
		end
	end

	assign head       = entries_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_W'(QDEPTH));

endmodule
`default_nettype wire

// ===== rtl/core/bmcv_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmcv_back
// Walks the 36 vertices of the cell at the queue head and drives the
// registered vertex output.
// ----------------------------------------------------------------------------
module bmcv_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         head_valid,
	input  wire bmcv_pkg::cell_rec_t          head,
	input  wire logic [bmcv_pkg::SIZE_W-1:0]  size_x,
	input  wire logic [bmcv_pkg::SIZE_W-1:0]  size_y,
	input  wire logic [bmcv_pkg::SIZE_W-1:0]  size_z,
	output logic                              pop,
	output logic                              vert_valid,
	input  wire logic                         vert_stall,
	output logic signed [bmcv_pkg::POS_W-1:0]  pos_x,
	output logic signed [bmcv_pkg::POS_W-1:0]  pos_y,
	output logic signed [bmcv_pkg::POS_W-1:0]  pos_z,
	output logic signed [bmcv_pkg::NORM_W-1:0] norm_x,
	output logic signed [bmcv_pkg::NORM_W-1:0] norm_y,
	output logic signed [bmcv_pkg::NORM_W-1:0] norm_z,
	output logic [bmcv_pkg::TEX_W-1:0]        tex_u,
	output logic [bmcv_pkg::TEX_W-1:0]        tex_v,
	output logic                              last_of_cell
);
	import bmcv_pkg::*;

	logic [2:0]        face_q;
	logic [2:0]        vtx_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic [NORM_W-1:0] norm_x_q, norm_y_q, norm_z_q;
	logic [TEX_W-1:0]  tex_u_q, tex_v_q;
	logic              last_q;

	logic              load;
	logic              last_vtx;
	logic              di, dj, neg;
	logic [POS_W-1:0]  half_x, half_y, half_z;
	logic [POS_W-1:0]  qx, qy, qzi, qzj;
	logic [TEX_W-1:0]  ti, tj;
	logic [POS_W-1:0]  px, py, pz;
	logic [NORM_W-1:0] nx, ny, nz;
	logic [TEX_W-1:0]  tu, tv;

	assign load     = head_valid && (!out_valid_q || !vert_stall);
	assign last_vtx = (face_q == FACE_BOTTOM) && (vtx_q == VTX_LAST);
	assign pop      = load && last_vtx;

	always_comb begin
		di  = FACE_DI[face_q][vtx_q];
		dj  = FACE_DJ[face_q][vtx_q];
		neg = face_q[0];
		half_x = {1'b0, size_x[SIZE_W-1:1]};
		half_y = {1'b0, size_y[SIZE_W-1:1]};
		half_z = {1'b0, size_z[SIZE_W-1:1]};
		qx  = di ? head.pq[1] : head.pq[0];
		qzi = di ? head.pq[3] : head.pq[2];
		qy  = dj ? head.pq[5] : head.pq[4];
		qzj = dj ? head.pq[7] : head.pq[6];
		ti  = di ? head.tq[1] : head.tq[0];
		tj  = dj ? head.tq[3] : head.tq[2];
		nx  = NORM_NIL;
		ny  = NORM_NIL;
		nz  = NORM_NIL;
		case (face_q)
			FACE_FRONT, FACE_BACK: begin
				px = half_x - qx;
				py = half_y - qy;
				pz = neg ? POS_W'(0) - half_z : half_z;
				nz = neg ? NORM_NEG : NORM_POS;
			end
			FACE_RIGHT, FACE_LEFT: begin
				px = neg ? POS_W'(0) - half_x : half_x;
				py = half_y - qy;
				pz = half_z - qzi;
				nx = neg ? NORM_NEG : NORM_POS;
			end
			default: begin
				px = half_x - qx;
				py = neg ? POS_W'(0) - half_y : half_y;
				pz = half_z - qzj;
				ny = neg ? NORM_NEG : NORM_POS;
			end
		endcase
		tu = FACE_U_FLIP[face_q] ? TEX_ONE - ti : ti;
		tv = FACE_V_FLIP[face_q] ? TEX_ONE - tj : tj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q      <= FACE_FRONT;
			vtx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || !vert_stall) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				if (vtx_q == VTX_LAST) begin
					vtx_q  <= '0;
					face_q <= last_vtx ? FACE_FRONT : face_q + 1'b1;
				end else begin
					vtx_q <= vtx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_x_q  <= px;
			pos_y_q  <= py;
			pos_z_q  <= pz;
			norm_x_q <= nx;
			norm_y_q <= ny;
			norm_z_q <= nz;
			tex_u_q  <= tu;
			tex_v_q  <= tv;
			last_q   <= last_vtx;
		end
	end

	assign vert_valid   = out_valid_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign norm_x       = norm_x_q;
	assign norm_y       = norm_y_q;
	assign norm_z       = norm_z_q;
	assign tex_u        = tex_u_q;
	assign tex_v        = tex_v_q;
	assign last_of_cell = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/box_mesh_cell_vertex_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_mesh_cell_vertex_generator
// Emits the 36 vertices of one grid cell of a subdivided box.
//
// Input channel cell_valid/cell_stall carries a cell index pair; output
// channel vert_valid/vert_stall carries one vertex per transaction, in face
// order front, back, right, left, top, bottom, six vertices per face, with
// last_of_cell set on the 36th. Sizes and divisions are written through the
// cfg_we/cfg_index/cfg_data port; the user must write them only while no cell
// is in progress, which the block itself does not enforce. Sustained rate:
// one vertex per cycle while vert_stall is low; the vertex walker sets the
// rate. A cell runs its twelve divisions through a 17-stage pipelined divider
// before its record is queued. Two cell records are held between the
// divider and the vertex walker, so the next cell is taken and divided while
// the current one is still being emitted.
// Reset clears the queue and counters and loads size 256 on each axis and
// one division. While vert_stall is high the current vertex holds and the
// queue fills; cell_stall is high once two cells are queued or being divided.
// ----------------------------------------------------------------------------
module box_mesh_cell_vertex_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bmcv_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [bmcv_pkg::SIZE_W-1:0]   cfg_data,
	input  wire logic                          cell_valid,
	output logic                               cell_stall,
	input  wire logic [bmcv_pkg::CELL_W-1:0]   cell_i,
	input  wire logic [bmcv_pkg::CELL_W-1:0]   cell_j,
	output logic                               vert_valid,
	input  wire logic                          vert_stall,
	output logic signed [bmcv_pkg::POS_W-1:0]  pos_x,
	output logic signed [bmcv_pkg::POS_W-1:0]  pos_y,
	output logic signed [bmcv_pkg::POS_W-1:0]  pos_z,
	output logic signed [bmcv_pkg::NORM_W-1:0] norm_x,
	output logic signed [bmcv_pkg::NORM_W-1:0] norm_y,
	output logic signed [bmcv_pkg::NORM_W-1:0] norm_z,
	output logic [bmcv_pkg::TEX_W-1:0]         tex_u,
	output logic [bmcv_pkg::TEX_W-1:0]         tex_v,
	output logic                               last_of_cell
);
	import bmcv_pkg::*;

	logic [SIZE_W-1:0] size_x_q;
	logic [SIZE_W-1:0] size_y_q;
	logic [SIZE_W-1:0] size_z_q;
	logic [DIV_W-1:0]  eff_div_q;
	logic [DIV_W-1:0]  div_wr;
	logic [DIV_W-1:0]  div_clamped;

	logic              rec_push;
	logic              rec_pop;
	cell_rec_t         rec_data;
	cell_rec_t         rec_head;
	fifo_stat_t        fifo_stat;

	// zero divisions acts as one, large counts saturate
	always_comb begin
		div_wr = cfg_data[DIV_W-1:0];
		if (div_wr == '0) begin
			div_clamped = DIV_W'(1);
		end else if (32'(div_wr) > MAX_DIV) begin
			div_clamped = DIV_W'(MAX_DIV);
		end else begin
			div_clamped = div_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= SIZE_RESET;
			size_y_q  <= SIZE_RESET;
			size_z_q  <= SIZE_RESET;
			eff_div_q <= DIV_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X:    size_x_q  <= cfg_data;
				REG_SIZE_Y:    size_y_q  <= cfg_data;
				REG_SIZE_Z:    size_z_q  <= cfg_data;
				REG_DIVISIONS: eff_div_q <= div_clamped;
				default:       ;
			endcase
		end
	end

	bmcv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.cell_i     (cell_i),
		.cell_j     (cell_j),
		.size_x     (size_x_q),
		.size_y     (size_y_q),
		.size_z     (size_z_q),
		.eff_div    (eff_div_q),
		.rec_pop    (rec_pop),
		.rec_push   (rec_push),
		.rec_data   (rec_data)
	);

	bmcv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec_data),
		.pop       (rec_pop),
		.head      (rec_head),
		.stat      (fifo_stat)
	);

	bmcv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!fifo_stat.empty),
		.head         (rec_head),
		.size_x       (size_x_q),
		.size_y       (size_y_q),
		.size_z       (size_z_q),
		.pop          (rec_pop),
		.vert_valid   (vert_valid),
		.vert_stall   (vert_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.last_of_cell (last_of_cell)
	);

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !fifo_stat.full)
		else $error("cell record pushed into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |-> !fifo_stat.empty)
		else $error("cell record popped from an empty queue");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_DIVISIONS) |=>
			(eff_div_q != '0) && (32'(eff_div_q) <= MAX_DIV))
		else $error("effective division count out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/box_mesh_cell_vertex_generator_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_mesh_cell_vertex_generator_tb
// Self-checking bench for the box mesh cell vertex generator. Cells are fed
// through the valid/stall input channel while vertices are taken from the
// output channel, with random gaps and stalls on both sides and one long
// output hold-off that backs the block up. Every accepted cell expands into
// 36 expected vertices computed locally from the current sizes and divisions,
// and each vertex is checked field by field in order. The run goes through
// the reset settings, directed extremes and several random settings.
// ----------------------------------------------------------------------------
module box_mesh_cell_vertex_generator_tb;

	localparam int MAX_DIVISIONS = 256;
	localparam int TEX_UNIT      = 65536;
	localparam int DRAIN_CYCLES  = 48;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_OFF      = 400;

	// per face: axis held at the half extent, its sign, axes driven by i and j
	localparam int FIXED_AX [6] = '{2, 2, 0, 0, 1, 1};
	localparam bit FIXED_NEG [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	localparam int I_AX [6] = '{0, 0, 2, 2, 0, 0};
	localparam int J_AX [6] = '{1, 1, 1, 1, 2, 2};
	localparam bit U_FLIP [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
	localparam bit V_FLIP [6] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
	// element v: offset of vertex v along i or j
	localparam logic [0:5] VERT_DI [6] = '{6'b010011, 6'b001011, 6'b001011,
		6'b010011, 6'b010011, 6'b001011};
	localparam logic [0:5] VERT_DJ [6] = '{6'b011001, 6'b011010, 6'b011010,
		6'b011001, 6'b100110, 6'b100101};

	typedef struct packed {
		logic [bmcv_pkg::CELL_W-1:0] i;
		logic [bmcv_pkg::CELL_W-1:0] j;
	} cell_t;

	typedef struct packed {
		logic [bmcv_pkg::POS_W-1:0]  px;
		logic [bmcv_pkg::POS_W-1:0]  py;
		logic [bmcv_pkg::POS_W-1:0]  pz;
		logic [bmcv_pkg::NORM_W-1:0] nx;
		logic [bmcv_pkg::NORM_W-1:0] ny;
		logic [bmcv_pkg::NORM_W-1:0] nz;
		logic [bmcv_pkg::TEX_W-1:0]  tu;
		logic [bmcv_pkg::TEX_W-1:0]  tv;
		logic                        last;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bmcv_pkg::IDX_W-1:0] cfg_index = '0;
	logic [bmcv_pkg::SIZE_W-1:0] cfg_data = '0;
	logic cell_valid = 1'b0;
	logic cell_stall;
	logic [bmcv_pkg::CELL_W-1:0] cell_i = '0;
	logic [bmcv_pkg::CELL_W-1:0] cell_j = '0;
	logic vert_valid;
	logic vert_stall = 1'b0;
	logic signed [bmcv_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [bmcv_pkg::NORM_W-1:0] norm_x, norm_y, norm_z;
	logic [bmcv_pkg::TEX_W-1:0] tex_u, tex_v;
	logic last_of_cell;

	// local copy of the register file
	logic [bmcv_pkg::SIZE_W-1:0] shadow_size_x = 16'd256;
	logic [bmcv_pkg::SIZE_W-1:0] shadow_size_y = 16'd256;
	logic [bmcv_pkg::SIZE_W-1:0] shadow_size_z = 16'd256;
	logic [bmcv_pkg::DIV_W-1:0]  shadow_div    = 9'd1;

	cell_t   pending_cells [$];
	vertex_t expected_vertices [$];
	int      mismatch_count = 0;
	int      idle_cycles = 0;
	int      cell_gap = 0;
	int      stall_left = 0;
	int      hold_left = 0;
	bit      cell_taken = 1'b0;
	bit      quiet_mode = 1'b0;
	bit      hold_req = 1'b0;
	bit      hold_done = 1'b0;

	box_mesh_cell_vertex_generator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.cell_i       (cell_i),
		.cell_j       (cell_j),
		.vert_valid   (vert_valid),
		.vert_stall   (vert_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.last_of_cell (last_of_cell)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int eff_divisions();
		if (shadow_div == 0) return 1;
		if (shadow_div > MAX_DIVISIONS) return MAX_DIVISIONS;
		return int'(shadow_div);
	endfunction

	function automatic int axis_coord(input int ext, input int k, input int d);
		return (ext >> 1) - (ext * k) / d;
	endfunction

	function automatic int tex_coord(input int k, input int d, input bit flip);
		int t;
		t = (k * TEX_UNIT) / d;
		if (t > TEX_UNIT) t = TEX_UNIT;
		return flip ? TEX_UNIT - t : t;
	endfunction

	// expands one accepted cell into its 36 vertices, face by face
	function automatic void emit_cell_vertices(input logic [bmcv_pkg::CELL_W-1:0] raw_i,
		input logic [bmcv_pkg::CELL_W-1:0] raw_j);
		int d, ci, cj, ki, kj, f, v, a, half;
		int ext [3];
		int pos [3];
		int nrm [3];
		vertex_t vx;
		d = eff_divisions();
		ci = (int'(raw_i) >= d) ? d - 1 : int'(raw_i);
		cj = (int'(raw_j) >= d) ? d - 1 : int'(raw_j);
		ext[0] = int'(shadow_size_x);
		ext[1] = int'(shadow_size_y);
		ext[2] = int'(shadow_size_z);
		for (f = 0; f < 6; f++) begin
			for (v = 0; v < 6; v++) begin
				ki = ci + int'(VERT_DI[f][v]);
				kj = cj + int'(VERT_DJ[f][v]);
				for (a = 0; a < 3; a++) nrm[a] = 0;
				half = ext[FIXED_AX[f]] >> 1;
				pos[FIXED_AX[f]] = FIXED_NEG[f] ? -half : half;
				nrm[FIXED_AX[f]] = FIXED_NEG[f] ? -1 : 1;
				pos[I_AX[f]] = axis_coord(ext[I_AX[f]], ki, d);
				pos[J_AX[f]] = axis_coord(ext[J_AX[f]], kj, d);
				vx.px = 16'(pos[0]);
				vx.py = 16'(pos[1]);
				vx.pz = 16'(pos[2]);
				vx.nx = 2'(nrm[0]);
				vx.ny = 2'(nrm[1]);
				vx.nz = 2'(nrm[2]);
				vx.tu = 17'(tex_coord(ki, d, U_FLIP[f]));
				vx.tv = 17'(tex_coord(kj, d, V_FLIP[f]));
				vx.last = (f == 5 && v == 5);
				expected_vertices.push_back(vx);
			end
		end
	endfunction

	// mostly back to back, some short pauses, a few long ones
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(16, 64);
	endfunction

	function automatic logic [15:0] rand_size();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd1;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [15:0] rand_div();
		int r;
		logic [15:0] val;
		r = $urandom_range(0, 99);
		if (r < 50) val = 16'($urandom_range(1, 8));
		else if (r < 80) val = 16'($urandom_range(9, 256));
		else val = 16'($urandom_range(0, 511));
		// bits above the register width are ignored
		if ($urandom_range(0, 3) == 0) val[15:9] = 7'($urandom);
		return val;
	endfunction

	task automatic check_field(input string field, input logic [16:0] want,
		input logic [16:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	task automatic write_reg(input logic [bmcv_pkg::IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bmcv_pkg::REG_SIZE_X:    shadow_size_x = val;
			bmcv_pkg::REG_SIZE_Y:    shadow_size_y = val;
			bmcv_pkg::REG_SIZE_Z:    shadow_size_z = val;
			bmcv_pkg::REG_DIVISIONS: shadow_div = val[8:0];
			default: ;
		endcase
	endtask

	task automatic set_box(input logic [15:0] sx, input logic [15:0] sy,
		input logic [15:0] sz, input logic [15:0] dv);
		write_reg(bmcv_pkg::REG_SIZE_X, sx);
		write_reg(bmcv_pkg::REG_SIZE_Y, sy);
		write_reg(bmcv_pkg::REG_SIZE_Z, sz);
		write_reg(bmcv_pkg::REG_DIVISIONS, dv);
	endtask

	task automatic add_cell(input int i, input int j);
		cell_t c;
		c.i = 8'(i);
		c.j = 8'(j);
		pending_cells.push_back(c);
	endtask

	task automatic wait_for_drain();
		while (pending_cells.size() != 0 || cell_valid || expected_vertices.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin : cell_driver
		cell_t next;
		if (!cell_valid || cell_taken) begin
			cell_taken = 1'b0;
			if (cell_gap > 0) begin
				cell_gap--;
				cell_valid <= 1'b0;
			end else if (pending_cells.size() != 0) begin
				next = pending_cells.pop_front();
				cell_i <= next.i;
				cell_j <= next.j;
				cell_valid <= 1'b1;
				cell_gap = quiet_mode ? 0 : idle_length();
			end else begin
				cell_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : vertex_pacer
		logic hold;
		if (hold_req && !hold_done) begin
			hold_left = HOLD_OFF;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			hold = 1'b1;
		end else if (quiet_mode) begin
			hold = 1'b0;
		end else begin
			if (stall_left == 0) stall_left = idle_length();
			hold = (stall_left > 0);
			if (hold) stall_left--;
		end
		vert_stall <= hold;
	end

	always @(posedge clk) begin : monitor
		vertex_t want, got;
		logic moved;
		moved = 1'b0;
		if (vert_valid && !vert_stall) begin
			moved = 1'b1;
			got.px = pos_x;
			got.py = pos_y;
			got.pz = pos_z;
			got.nx = norm_x;
			got.ny = norm_y;
			got.nz = norm_z;
			got.tu = tex_u;
			got.tv = tex_v;
			got.last = last_of_cell;
			if (expected_vertices.size() == 0) begin
				$display("%0t: vertex with none expected, expected none, got %h", $time, got);
				mismatch_count++;
			end else begin
				want = expected_vertices.pop_front();
				check_field("pos_x", want.px, got.px);
				check_field("pos_y", want.py, got.py);
				check_field("pos_z", want.pz, got.pz);
				check_field("norm_x", want.nx, got.nx);
				check_field("norm_y", want.ny, got.ny);
				check_field("norm_z", want.nz, got.nz);
				check_field("tex_u", want.tu, got.tu);
				check_field("tex_v", want.tv, got.tv);
				check_field("last_of_cell", want.last, got.last);
			end
		end
		if (cell_valid && !cell_stall) begin
			moved = 1'b1;
			cell_taken = 1'b1;
			emit_cell_vertices(cell_i, cell_j);
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int ph, n, d;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: cube of size 256, one division, indices clamp to zero
		add_cell(0, 0);
		add_cell(255, 255);
		add_cell(8'hAA, 8'h55);
		wait_for_drain();

		// widest, thinnest and flat axes at the largest division count
		set_box(16'hFFFF, 16'd1, 16'd0, 16'd256);
		add_cell(0, 0);
		add_cell(255, 255);
		add_cell(255, 0);
		add_cell(0, 255);
		add_cell(8'h55, 8'hAA);
		add_cell(127, 128);
		wait_for_drain();

		// zero divisions behave as one; odd sizes drop the low bit
		set_box(16'd257, 16'd3, 16'hFFFF, 16'd0);
		add_cell(0, 0);
		add_cell(200, 100);
		wait_for_drain();

		// divisions beyond the maximum saturate
		set_box(16'h8000, 16'h7FFF, 16'd2, 16'd511);
		add_cell(255, 255);
		add_cell(0, 0);
		add_cell(100, 3);
		wait_for_drain();

		set_box(16'd255, 16'hFFFF, 16'd1000, 16'd3);
		add_cell(2, 2);
		add_cell(3, 1);
		add_cell(1, 0);
		add_cell(0, 2);
		wait_for_drain();

		for (ph = 0; ph < 4; ph++) begin
			quiet_mode = (ph == 1);
			set_box(rand_size(), rand_size(), rand_size(), rand_div());
			d = eff_divisions();
			// long output hold-off while cells keep coming
			if (ph == 2) hold_req = 1'b1;
			for (n = 0; n < 25; n++) begin
				if ($urandom_range(0, 3) != 0)
					add_cell($urandom_range(0, d - 1), $urandom_range(0, d - 1));
				else
					add_cell($urandom_range(0, 255), $urandom_range(0, 255));
			end
			wait_for_drain();
		end

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== box_mesh_cell_vertex_generator.f =====
rtl/core/bmcv_pkg.sv
rtl/core/bmcv_div.sv
rtl/core/bmcv_front.sv
rtl/core/bmcv_fifo.sv
rtl/core/bmcv_back.sv
rtl/core/box_mesh_cell_vertex_generator.sv
tb/box_mesh_cell_vertex_generator_tb.sv
